FILE: hdl/ssbd_pkg.sv
// ----------------------------------------------------------------------------
// ssbd_pkg
// Shared types and constants of the distance-ordered record stack.
// ----------------------------------------------------------------------------
package ssbd_pkg;

    localparam int FIELD_W = 16;

    // one stored record: distance in the upper half, code in the lower half
    typedef struct packed {
        logic [FIELD_W-1:0] distance;
        logic [FIELD_W-1:0] code;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // control from the sequencer to the minimum tracker
    typedef struct packed {
        logic clear;
        logic upd;
    } t_scan_ctl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

FILE: hdl/ssbd_rec_mem.sv
// ----------------------------------------------------------------------------
// ssbd_rec_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssbd_rec_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  ssbd_pkg::t_rec      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output ssbd_pkg::t_rec      o_rdata
);

    ssbd_pkg::t_rec r_mem [DEPTH];
    ssbd_pkg::t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ssbd_min_scan.sv
// ----------------------------------------------------------------------------
// ssbd_min_scan
// Tracks the smallest-distance record seen during one pass over the store.
// ----------------------------------------------------------------------------
module ssbd_min_scan #(
    parameter int AW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssbd_pkg::t_scan_ctl   i_ctl,
    input  ssbd_pkg::t_rec        i_rec,
    input  logic [AW-1:0]         i_idx,
    output ssbd_pkg::t_rec        o_best_rec,
    output logic [AW-1:0]         o_best_idx
);

    logic           r_have;
    logic           n_have;
    ssbd_pkg::t_rec r_best_rec;
    logic [AW-1:0]  r_best_idx;
    logic           take;

    // strict less-than keeps the earliest entry among equal distances
    assign take = i_ctl.upd && (!r_have || (i_rec.distance < r_best_rec.distance));

    always_comb begin
        n_have = r_have;
        if (i_ctl.clear) begin
            n_have = 1'b0;
        end else if (take) begin
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    // candidate payload
    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_best_rec <= i_rec;
            r_best_idx <= i_idx;
        end
    end

    assign o_best_rec = r_best_rec;
    assign o_best_idx = r_best_idx;

endmodule

FILE: hdl/stack_sort_by_distance_unit.sv
// ----------------------------------------------------------------------------
// stack_sort_by_distance_unit
// Bounded record stack that emits its contents in ascending distance.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one record word per cycle
// while loading. Each word is pushed into the record memory; once the store
// holds STACK_DEPTH records further words are dropped and a sticky flag is
// set. A word with i_end_of_load high is pushed like any other and starts
// the output run.
// Output channel (o_out_valid / i_out_stall) then delivers every stored
// record, smallest distance first, equal distances in arrival order, with
// o_out_last on the final word and o_dropped_any on every word of the run.
// Each output word comes from one pass over the n stored records through
// the single read port of the record memory: the records are read in order,
// each read word is checked by the minimum tracker, and the best word then
// goes to the output register. o_in_stall is high from the end-of-load
// word until the final word has been loaded into the output register.
// A stalled output word holds; the next pass runs behind it and waits.
// Reset empties the store and clears the flag; memory contents need none.
// ----------------------------------------------------------------------------
module stack_sort_by_distance_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ssbd_pkg::FIELD_W-1:0]   i_order_code,
    input  logic [ssbd_pkg::FIELD_W-1:0]   i_order_distance,
    input  logic                           i_end_of_load,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ssbd_pkg::FIELD_W-1:0]   o_out_code,
    output logic [ssbd_pkg::FIELD_W-1:0]   o_out_distance,
    output logic                           o_out_last,
    output logic                           o_dropped_any
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    ssbd_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [STACK_DEPTH-1:0] r_taken, n_taken;
    logic [CW-1:0]        r_scan_idx, n_scan_idx;
    logic                 r_chk_vld, n_chk_vld;
    logic [AW-1:0]        r_chk_idx, n_chk_idx;
    logic [CW-1:0]        r_emit_cnt, n_emit_cnt;
    logic                 r_out_valid, n_out_valid;

    ssbd_pkg::t_rec       r_out_rec, n_out_rec;
    logic                 r_out_last, n_out_last;
    logic                 r_out_drop, n_out_drop;
    logic                 out_load;

    logic                 in_acc;
    logic                 room;
    logic                 out_free;
    logic                 rd_en;
    ssbd_pkg::t_rec       wr_rec;
    ssbd_pkg::t_rec       rd_rec;
    ssbd_pkg::t_rec       best_rec;
    logic [AW-1:0]        best_idx;
    ssbd_pkg::t_scan_ctl  scan_ctl;
    logic                 last_emit;

    assign in_acc   = i_in_valid && (r_state == ssbd_pkg::S_LOAD);
    assign room     = (r_count < CW'(STACK_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;
    assign wr_rec   = '{distance: i_order_distance, code: i_order_code};
    assign last_emit = ((r_emit_cnt + CW'(1)) == r_count);

    // record memory
    ssbd_rec_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_rec),
        .i_re    (rd_en),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (rd_rec)
    );

    // minimum tracker for the current pass
    ssbd_min_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_rec      (rd_rec),
        .i_idx      (r_chk_idx),
        .o_best_rec (best_rec),
        .o_best_idx (best_idx)
    );

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_taken     = r_taken;
        n_scan_idx  = r_scan_idx;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_scan_idx[AW-1:0];
        n_emit_cnt  = r_emit_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rec   = r_out_rec;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        out_load    = 1'b0;
        rd_en       = 1'b0;
        scan_ctl    = '{clear: 1'b0, upd: 1'b0};

        case (r_state)
            ssbd_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    // a final word always leaves at least one stored record
                    if (i_end_of_load) begin
                        n_state        = ssbd_pkg::S_SCAN;
                        n_taken        = '0;
                        n_scan_idx     = '0;
                        n_emit_cnt     = '0;
                        scan_ctl.clear = 1'b1;
                    end
                end
            end
            ssbd_pkg::S_SCAN: begin
                // issue reads in order, check each word once its registered read data returns
                rd_en = (r_scan_idx < r_count);
                if (rd_en) begin
                    n_scan_idx = r_scan_idx + CW'(1);
                end
                n_chk_vld    = rd_en;
                scan_ctl.upd = r_chk_vld && !r_taken[r_chk_idx];
                if (r_chk_vld && (CW'(r_chk_idx) == (r_count - CW'(1)))) begin
                    n_state = ssbd_pkg::S_EMIT;
                end
            end
            ssbd_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out_rec          = best_rec;
                    n_out_last         = last_emit;
                    n_out_drop         = r_ovf;
                    n_taken[best_idx]  = 1'b1;
                    n_emit_cnt         = r_emit_cnt + CW'(1);
                    if (last_emit) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ssbd_pkg::S_LOAD;
                    end else begin
                        n_scan_idx     = '0;
                        scan_ctl.clear = 1'b1;
                        n_state        = ssbd_pkg::S_SCAN;
                    end
                end
            end
            default: begin
                n_state = ssbd_pkg::S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssbd_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_taken     <= '0;
            r_scan_idx  <= '0;
            r_chk_vld   <= 1'b0;
            r_chk_idx   <= '0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_taken     <= n_taken;
            r_scan_idx  <= n_scan_idx;
            r_chk_vld   <= n_chk_vld;
            r_chk_idx   <= n_chk_idx;
            r_emit_cnt  <= n_emit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rec  <= n_out_rec;
            r_out_last <= n_out_last;
            r_out_drop <= n_out_drop;
        end
    end

    assign o_in_stall     = (r_state != ssbd_pkg::S_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_out_code     = r_out_rec.code;
    assign o_out_distance = r_out_rec.distance;
    assign o_out_last     = r_out_last;
    assign o_dropped_any  = r_out_drop;

endmodule
